// File: hw/rtl/yab_pkg.sv
package yab_pkg;

    localparam int COEF_FRAC_BITS_DEF = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

    localparam logic MODE_FADE    = 1'b0;
    localparam logic MODE_OVERLAY = 1'b1;

    localparam int RGB_W   = 12;
    localparam int CHAN_W  = 13;
    localparam int BLEND_W = 29;

endpackage

// File: hw/rtl/yuv_alpha_blend_pipeline.sv
// Result: each request taken at a clock edge passes through the stages in order; its result is on
// the ports from the last stage's registers, with done high for one cycle.
// Throughput: one request every cycle, set by the six-stage pipeline; busy stays low.
// The receiver cannot stall, so no stage ever holds.
// Reset (rst_n low, asynchronous) clears the stage valid bits, alpha and blend_mode.
module yuv_alpha_blend_pipeline #(
    parameter int COEF_FRAC_BITS = yab_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [yab_pkg::PIX_W-1:0]      y_first,
    input  logic [yab_pkg::PIX_W-1:0]      u_first,
    input  logic [yab_pkg::PIX_W-1:0]      v_first,
    input  logic [yab_pkg::PIX_W-1:0]      y_second,
    input  logic [yab_pkg::PIX_W-1:0]      u_second,
    input  logic [yab_pkg::PIX_W-1:0]      v_second,
    input  logic                           chroma_site,
    output logic                           done,
    output logic [yab_pkg::PIX_W-1:0]      y_out,
    output logic [yab_pkg::PIX_W-1:0]      u_out,
    output logic [yab_pkg::PIX_W-1:0]      v_out,
    output logic                           chroma_valid,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [yab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yab_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = F + 3;
    localparam int YQW = F + 9;
    localparam int PW1 = CW + 8;
    localparam int SW1 = F + 12;
    localparam int PW2 = CW + yab_pkg::CHAN_W;
    localparam int SW2 = F + 14;
    localparam int RW  = yab_pkg::RGB_W;
    localparam int CHW = yab_pkg::CHAN_W;
    localparam int BW  = yab_pkg::BLEND_W;

    localparam logic signed [CW-1:0] K_RV = CW'(((1140 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_GU = CW'(((394 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_GV = CW'(((581 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_BU = CW'(((2032 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_YR = CW'(((299 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_YG = CW'(((587 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_YB = CW'(((114 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_UR = CW'(((147 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_UG = CW'(((289 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_UB = CW'(((436 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_VR = CW'(((615 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_VG = CW'(((515 << F) + 500) / 1000);
    localparam logic signed [CW-1:0] K_VB = CW'(((100 << F) + 500) / 1000);

    localparam logic signed [SW1-1:0] BIAS1 = SW1'((1 << F) - 1);
    localparam logic signed [SW2-1:0] BIAS2 = SW2'((1 << F) - 1);
    localparam logic signed [SW2-1:0] HALF  = SW2'(128 << F);

    function automatic logic signed [RW-1:0] trunc_rgb(input logic signed [SW1-1:0] x);
        logic signed [SW1-1:0] b;
        logic signed [SW1-1:0] sh;
        b  = x + (x[SW1-1] ? BIAS1 : SW1'(0));
        sh = b >>> F;
        return sh[RW-1:0];
    endfunction

    function automatic logic [7:0] trunc_clamp(input logic signed [SW2-1:0] x);
        logic signed [SW2-1:0] b;
        logic signed [SW2-1:0] sh;
        logic signed [13:0]    t;
        b  = x + (x[SW2-1] ? BIAS2 : SW2'(0));
        sh = b >>> F;
        t  = sh[13:0];
        if (t < 14'sd0)
            return 8'd0;
        else if (t > 14'sd255)
            return 8'd255;
        else
            return t[7:0];
    endfunction

    logic [7:0] alpha_reg;
    logic       blend_mode_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg      <= 8'd0;
            blend_mode_reg <= yab_pkg::MODE_FADE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                yab_pkg::CFG_ALPHA: alpha_reg      <= cfg_data[7:0];
                yab_pkg::CFG_MODE:  blend_mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // valid chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // stage 1: chroma products
    logic [7:0]             y_in [2];
    logic [7:0]             u_in [2];
    logic [7:0]             v_in [2];
    logic signed [7:0]      du_next [2];
    logic signed [7:0]      dv_next [2];
    logic signed [YQW-1:0]  yq1_reg [2];
    logic signed [PW1-1:0]  rv1_reg [2];
    logic signed [PW1-1:0]  gu1_reg [2];
    logic signed [PW1-1:0]  gv1_reg [2];
    logic signed [PW1-1:0]  bu1_reg [2];
    logic                   site1_reg;

    assign y_in[0] = y_first;
    assign u_in[0] = u_first;
    assign v_in[0] = v_first;
    assign y_in[1] = y_second;
    assign u_in[1] = u_second;
    assign v_in[1] = v_second;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            du_next[i] = {~u_in[i][7], u_in[i][6:0]};
            dv_next[i] = {~v_in[i][7], v_in[i][6:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            yq1_reg[i] <= $signed({1'b0, y_in[i], {F{1'b0}}});
            rv1_reg[i] <= PW1'(K_RV) * PW1'(dv_next[i]);
            gu1_reg[i] <= PW1'(K_GU) * PW1'(du_next[i]);
            gv1_reg[i] <= PW1'(K_GV) * PW1'(dv_next[i]);
            bu1_reg[i] <= PW1'(K_BU) * PW1'(du_next[i]);
        end
        site1_reg <= chroma_site;
    end

    // stage 2: sum and truncate to RGB
    logic signed [SW1-1:0] yqe [2];
    logic signed [RW-1:0]  r2_next [2];
    logic signed [RW-1:0]  g2_next [2];
    logic signed [RW-1:0]  b2_next [2];
    logic signed [RW-1:0]  r2_reg [2];
    logic signed [RW-1:0]  g2_reg [2];
    logic signed [RW-1:0]  b2_reg [2];
    logic                  site2_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            yqe[i]     = SW1'(yq1_reg[i]);
            r2_next[i] = trunc_rgb(yqe[i] + SW1'(rv1_reg[i]));
            g2_next[i] = trunc_rgb(yqe[i] - SW1'(gu1_reg[i]) - SW1'(gv1_reg[i]));
            b2_next[i] = trunc_rgb(yqe[i] + SW1'(bu1_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg    <= r2_next;
        g2_reg    <= g2_next;
        b2_reg    <= b2_next;
        site2_reg <= site1_reg;
    end

    // stage 3: scale by alpha
    logic signed [RW-1:0]  c1 [3];
    logic signed [RW-1:0]  c2 [3];
    logic signed [CHW-1:0] d3 [3];
    logic [RW-1:0]         x3 [3];
    logic signed [15:0]    s3 [3];
    logic signed [12:0]    a13;
    logic signed [BW-1:0]  m3_next [3];
    logic signed [BW-1:0]  m3_reg [3];
    logic signed [RW-1:0]  c2_3_reg [3];
    logic                  mode3_reg;
    logic                  site3_reg;

    assign c1[0] = r2_reg[0];
    assign c1[1] = g2_reg[0];
    assign c1[2] = b2_reg[0];
    assign c2[0] = r2_reg[1];
    assign c2[1] = g2_reg[1];
    assign c2[2] = b2_reg[1];
    assign a13   = $signed({1'b0, alpha_reg, 4'b0000});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d3[k]      = CHW'(c1[k]) - CHW'(c2[k]);
            x3[k]      = (blend_mode_reg == yab_pkg::MODE_OVERLAY) ? d3[k][RW-1:0] : c1[k];
            s3[k]      = $signed({x3[k], 4'b0000});
            m3_next[k] = BW'(s3[k]) * BW'(a13);
        end
    end

    always_ff @(posedge clk)
    begin
        m3_reg    <= m3_next;
        c2_3_reg  <= c2;
        mode3_reg <= blend_mode_reg;
        site3_reg <= site2_reg;
    end

    // stage 4: floor, and add image two in overlay mode
    logic signed [CHW-1:0] f4 [3];
    logic signed [CHW-1:0] c4_next [3];
    logic signed [CHW-1:0] c4_reg [3];
    logic                  site4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            f4[k]      = m3_reg[k][BW-1:16];
            c4_next[k] = (mode3_reg == yab_pkg::MODE_OVERLAY) ? f4[k] + CHW'(c2_3_reg[k])
                                                              : f4[k];
        end
    end

    always_ff @(posedge clk)
    begin
        c4_reg    <= c4_next;
        site4_reg <= site3_reg;
    end

    // stage 5: YUV products
    logic signed [PW2-1:0] yr5_reg, yg5_reg, yb5_reg;
    logic signed [PW2-1:0] ur5_reg, ug5_reg, ub5_reg;
    logic signed [PW2-1:0] vr5_reg, vg5_reg, vb5_reg;
    logic                  site5_reg;

    always_ff @(posedge clk)
    begin
        yr5_reg   <= PW2'(K_YR) * PW2'(c4_reg[0]);
        yg5_reg   <= PW2'(K_YG) * PW2'(c4_reg[1]);
        yb5_reg   <= PW2'(K_YB) * PW2'(c4_reg[2]);
        ur5_reg   <= PW2'(K_UR) * PW2'(c4_reg[0]);
        ug5_reg   <= PW2'(K_UG) * PW2'(c4_reg[1]);
        ub5_reg   <= PW2'(K_UB) * PW2'(c4_reg[2]);
        vr5_reg   <= PW2'(K_VR) * PW2'(c4_reg[0]);
        vg5_reg   <= PW2'(K_VG) * PW2'(c4_reg[1]);
        vb5_reg   <= PW2'(K_VB) * PW2'(c4_reg[2]);
        site5_reg <= site4_reg;
    end

    // stage 6: sum, truncate, clamp; chroma zeroed off a chroma site
    logic signed [SW2-1:0] ys6, us6, vs6;
    logic [7:0]            y_out_reg, u_out_reg, v_out_reg;
    logic                  cv_reg;

    always_comb
    begin
        ys6 = SW2'(yr5_reg) + SW2'(yg5_reg) + SW2'(yb5_reg);
        us6 = SW2'(ub5_reg) - SW2'(ur5_reg) - SW2'(ug5_reg) + HALF;
        vs6 = SW2'(vr5_reg) - SW2'(vg5_reg) - SW2'(vb5_reg) + HALF;
    end

    always_ff @(posedge clk)
    begin
        y_out_reg <= trunc_clamp(ys6);
        u_out_reg <= site5_reg ? trunc_clamp(us6) : 8'd0;
        v_out_reg <= site5_reg ? trunc_clamp(vs6) : 8'd0;
        cv_reg    <= site5_reg;
    end

    assign done         = done_reg;
    assign y_out        = y_out_reg;
    assign u_out        = u_out_reg;
    assign v_out        = v_out_reg;
    assign chroma_valid = cv_reg;

`ifndef SYNTH
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !chroma_valid) |-> (u_out == 8'd0 && v_out == 8'd0))
        else $error("chroma fields not zero off a chroma site");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |=> done)
        else $error("result strobe lost in last stage");

    a_alpha_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == yab_pkg::CFG_ALPHA) |=> alpha_reg == $past(cfg_data))
        else $error("alpha write not taken");

    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |=> ##1 !done)
        else $error("result strobe without a request");
`endif

endmodule
